// ----- sv/lfq_pkg.sv -----
// lfq_pkg: constants and types shared by the lpc frame quantizer and its checker
// no dependencies
`default_nettype none

package lfq_pkg;

  localparam int unsigned GainW    = 25;
  localparam int unsigned PitchW   = 9;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned NumCoef  = 10;
  localparam int unsigned NumSteps = 15;
  localparam int unsigned FrameW   = 64;

  // |coef| limit is 2.0 in Q3.12, offset coef sits in 0..16384
  localparam int unsigned OffW  = 15;
  // (t * 15 + 8192) stays below 2^18
  localparam int unsigned ProdW = 18;
  localparam int unsigned CodeShift = 14;

  localparam logic [11:0] SyncWord = 12'hA55;

  localparam logic signed [CoefW-1:0] CoefMax = 16'sd8192;
  localparam logic signed [CoefW-1:0] CoefMin = -16'sd8192;
  localparam logic [OffW-1:0]  CoefOffset = 15'd8192;
  localparam logic [ProdW-1:0] CodeRound  = 18'd8192;
  localparam logic [3:0]       CodeLevels = 4'd15;

  localparam logic [PitchW-1:0] PitchOffset = 9'd19;
  localparam logic [PitchW-1:0] PitchLow    = 9'd20;   // below this (zero apart) the code sits at 1
  localparam logic [PitchW-1:0] PitchHigh   = 9'd142;  // above this the code sits at 123
  localparam logic [6:0]        PitchCodeMin = 7'd1;
  localparam logic [6:0]        PitchCodeMax = 7'd123;

  // smallest Q1.24 value not below 2^((k-0.5)/1.5 - 10), k = 1..15
  localparam logic [GainW-1:0] GainStep [NumSteps] = '{
    25'd20643,   25'd32768,   25'd52016,   25'd82571,   25'd131072,
    25'd208064,  25'd330281,  25'd524288,  25'd832256,  25'd1321123,
    25'd2097152, 25'd3329022, 25'd5284492, 25'd8388608, 25'd13316086
  };

  typedef logic [OffW-1:0]  coef_off_t;
  typedef logic [ProdW-1:0] coef_prod_t;

endpackage

`default_nettype wire

// ----- sv/lpc_frame_quantizer.sv -----
// lpc_frame_quantizer: three-stage pipeline that packs one lpc frame into a 64-bit word
// depends on lfq_pkg
//
//   channel   signals                              direction
//   input     start_i, busy_o, gain_i, pitch_i,    in (busy_o out)
//             coef_1_i .. coef_10_i
//   result    done_o, frame_word_o                 out
//
// one item may enter every cycle; its word comes out on frame_word_o with done_o
// after passing the three register stages (clamp and compare, constant multiply
// and count, round and pack).
// busy_o stays low, the receiver takes every result as it comes.
// rst_ni clears the stage valid bits; items in flight are dropped.
`default_nettype none

module lpc_frame_quantizer import lfq_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [GainW-1:0]         gain_i,
  input  wire logic [PitchW-1:0]        pitch_i,
  input  wire logic signed [CoefW-1:0]  coef_1_i,
  input  wire logic signed [CoefW-1:0]  coef_2_i,
  input  wire logic signed [CoefW-1:0]  coef_3_i,
  input  wire logic signed [CoefW-1:0]  coef_4_i,
  input  wire logic signed [CoefW-1:0]  coef_5_i,
  input  wire logic signed [CoefW-1:0]  coef_6_i,
  input  wire logic signed [CoefW-1:0]  coef_7_i,
  input  wire logic signed [CoefW-1:0]  coef_8_i,
  input  wire logic signed [CoefW-1:0]  coef_9_i,
  input  wire logic signed [CoefW-1:0]  coef_10_i,
  output logic                          done_o,
  output logic [FrameW-1:0]             frame_word_o
);

  logic signed [CoefW-1:0] coef_in [NumCoef];

  // stage 1
  logic                 v1_q;
  logic [NumSteps-1:0]  therm_d, therm_q;
  logic                 voiced1_d, voiced1_q;
  logic [6:0]           pcode1_d, pcode1_q;
  coef_off_t            off_d [NumCoef];
  coef_off_t            off_q [NumCoef];

  // stage 2
  logic                 v2_q;
  logic [3:0]           gcode_d, gcode_q;
  logic                 voiced2_q;
  logic [6:0]           pcode2_q;
  coef_prod_t           prod_d [NumCoef];
  coef_prod_t           prod_q [NumCoef];

  // stage 3
  logic                 v3_q;
  logic [FrameW-1:0]    frame_d, frame_q;

  logic                 accept;

  assign coef_in = '{coef_1_i, coef_2_i, coef_3_i, coef_4_i, coef_5_i,
                     coef_6_i, coef_7_i, coef_8_i, coef_9_i, coef_10_i};

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage 1: threshold compares, pitch code, coefficient clamp and offset
  always_comb begin
    logic signed [CoefW-1:0] a;
    logic [PitchW-1:0]       pdiff;
    a     = '0;
    pdiff = pitch_i - PitchOffset;
    for (int k = 0; k < NumSteps; k++) begin
      therm_d[k] = (gain_i >= GainStep[k]);
    end
    voiced1_d = (pitch_i != '0);
    if (!voiced1_d) begin
      pcode1_d = '0;
    end else if (pitch_i < PitchLow) begin
      pcode1_d = PitchCodeMin;
    end else if (pitch_i > PitchHigh) begin
      pcode1_d = PitchCodeMax;
    end else begin
      pcode1_d = pdiff[6:0];
    end
    for (int c = 0; c < NumCoef; c++) begin
      if (coef_in[c] < CoefMin) begin
        a = CoefMin;
      end else if (coef_in[c] > CoefMax) begin
        a = CoefMax;
      end else begin
        a = coef_in[c];
      end
      off_d[c] = coef_off_t'(a[OffW-1:0] + CoefOffset);
    end
  end

  // stage 2: count reached thresholds, scale offset coefficient by 15
  always_comb begin
    gcode_d = '0;
    for (int k = 0; k < NumSteps; k++) begin
      gcode_d = gcode_d + 4'(therm_q[k]);
    end
    for (int c = 0; c < NumCoef; c++) begin
      prod_d[c] = coef_prod_t'(off_q[c]) * coef_prod_t'(CodeLevels);
    end
  end

  // stage 3: round, take code bits and pack the word
  always_comb begin
    coef_prod_t r;
    r       = '0;
    frame_d = {SyncWord, gcode_q, voiced2_q, pcode2_q, 40'd0};
    for (int c = 0; c < NumCoef; c++) begin
      r = prod_q[c] + CodeRound;
      frame_d[4*(NumCoef-1-c) +: 4] = r[CodeShift +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      therm_q   <= therm_d;
      voiced1_q <= voiced1_d;
      pcode1_q  <= pcode1_d;
      off_q     <= off_d;
    end
    if (v1_q) begin
      gcode_q   <= gcode_d;
      voiced2_q <= voiced1_q;
      pcode2_q  <= pcode1_q;
      prod_q    <= prod_d;
    end
    if (v2_q) begin
      frame_q <= frame_d;
    end
  end

  assign done_o       = v3_q;
  assign frame_word_o = frame_q;

endmodule

`default_nettype wire

// ----- sv/lfq_checker.sv -----
// lfq_checker: port-level checks on the lpc frame quantizer, bound to the top level
// depends on lfq_pkg and lpc_frame_quantizer
`default_nettype none

module lfq_checker import lfq_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic [GainW-1:0]  gain_i,
  input wire logic              done_o,
  input wire logic [FrameW-1:0] frame_word_o
);

  // every accepted item comes out with done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 done_o)
    else $error("accepted item did not come out after three cycles");

  // no result without an accepted item ahead of it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##3 !done_o)
    else $error("result strobe without an accepted item");

  a_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> frame_word_o[63:52] == SyncWord)
    else $error("sync field wrong");

  // unvoiced frames carry pitch code zero, voiced ones never do
  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (frame_word_o[47] == (frame_word_o[46:40] != 7'd0)))
    else $error("voiced bit and pitch code disagree");

  a_gain_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && gain_i == '0 |-> ##3 frame_word_o[51:48] == 4'd0)
    else $error("zero gain gave nonzero gain code");

endmodule

bind lpc_frame_quantizer lfq_checker u_lfq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .gain_i       (gain_i),
  .done_o       (done_o),
  .frame_word_o (frame_word_o)
);

`default_nettype wire

// ----- tb/sv/lpc_frame_quantizer_tb.sv -----
// lpc_frame_quantizer_tb: self-checking bench for the lpc frame quantizer
// depends on lfq_pkg and lpc_frame_quantizer; predicts every packed word and checks it
module lpc_frame_quantizer_tb;
  import lfq_pkg::*;

  localparam int unsigned RandItems = 550;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportMax = 10;

  // notes accepted frames, predicts their packed words and checks the results
  class frame_checker;
    logic [63:0] pending_words[$];
    int unsigned errors;

    function logic [3:0] gain_level(logic [24:0] gain);
      int unsigned edges [15];
      logic [3:0] level;
      edges = '{20643, 32768, 52016, 82571, 131072, 208064, 330281, 524288,
                 832256, 1321123, 2097152, 3329022, 5284492, 8388608, 13316086};
      level = 0;
      foreach (edges[i]) begin
        if (gain >= edges[i]) level++;
      end
      return level;
    endfunction

    function logic [3:0] coef_level(logic signed [15:0] coef);
      int v;
      v = coef;
      if (v < -8192) v = -8192;
      if (v > 8192) v = 8192;
      v = ((v + 8192) * 15 + 8192) >> 14;
      return v[3:0];
    endfunction

    function logic [63:0] pack_frame(logic [24:0] gain, logic [8:0] pitch,
                                     logic signed [15:0] coefs [10]);
      logic [63:0] word;
      logic [6:0] pitch_code;
      pitch_code = 0;
      if (pitch == 0) pitch_code = 0;
      else if (pitch < 20) pitch_code = 1;
      else if (pitch > 142) pitch_code = 123;
      else pitch_code = 7'(pitch - 19);
      word = {12'hA55, gain_level(gain), pitch != 0, pitch_code, 40'd0};
      for (int k = 0; k < 10; k++) begin
        word[39 - 4 * k -: 4] = coef_level(coefs[k]);
      end
      return word;
    endfunction

    function void note_frame(logic [24:0] gain, logic [8:0] pitch,
                             logic signed [15:0] coefs [10]);
      pending_words.push_back(pack_frame(gain, pitch, coefs));
    endfunction

    function void check_word(logic [63:0] actual);
      logic [63:0] want;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= ReportMax) $display("unexpected frame word %h", actual);
        return;
      end
      want = pending_words.pop_front();
      if (actual !== want) begin
        errors++;
        if (errors <= ReportMax) $display("frame word mismatch: expected %h got %h", want, actual);
      end
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [GainW-1:0] gain_i;
  logic [PitchW-1:0] pitch_i;
  logic signed [CoefW-1:0] coef_in [NumCoef];
  logic done_o;
  logic [FrameW-1:0] frame_word_o;

  frame_checker sb = new();
  int unsigned cycles;

  lpc_frame_quantizer uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .gain_i(gain_i), .pitch_i(pitch_i),
    .coef_1_i(coef_in[0]), .coef_2_i(coef_in[1]), .coef_3_i(coef_in[2]),
    .coef_4_i(coef_in[3]), .coef_5_i(coef_in[4]), .coef_6_i(coef_in[5]),
    .coef_7_i(coef_in[6]), .coef_8_i(coef_in[7]), .coef_9_i(coef_in[8]),
    .coef_10_i(coef_in[9]),
    .done_o(done_o), .frame_word_o(frame_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pre-edge values: an item is taken when start is high and busy is low
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) sb.note_frame(gain_i, pitch_i, coef_in);
    if (rst_ni && done_o) sb.check_word(frame_word_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_frame(logic [24:0] gain, logic [8:0] pitch,
                            logic signed [15:0] coefs [10]);
    start_i <= 1'b1;
    gain_i <= gain;
    pitch_i <= pitch;
    foreach (coefs[k]) coef_in[k] <= coefs[k];
    do @(posedge clk_i); while (busy_o);
  endtask

  // start low with junk on the data ports
  task automatic hold_off(int unsigned n);
    if (n == 0) return;
    start_i <= 1'b0;
    gain_i <= GainW'($urandom);
    pitch_i <= PitchW'($urandom);
    foreach (coef_in[k]) coef_in[k] <= CoefW'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_frames();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [24:0] rand_gain();
    int v;
    v = 0;
    case ($urandom_range(0, 3))
      0: v = int'($urandom & 32'h1FF_FFFF);
      1: v = int'(GainStep[$urandom_range(0, NumSteps - 1)]) + int'($urandom_range(0, 4)) - 2;
      2: v = int'($urandom >> $urandom_range(7, 31));
      default: v = int'($urandom_range(0, 40000));
    endcase
    return v[24:0];
  endfunction

  function automatic logic [8:0] rand_pitch();
    case ($urandom_range(0, 4))
      0: return 9'd0;
      1: return 9'($urandom_range(1, 25));
      2: return 9'($urandom_range(135, 150));
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_coef();
    int t;
    t = 0;
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 16384) - 8192);
      2: return 16'(($urandom_range(0, 1) ? 8192 : -8192) + int'($urandom_range(0, 6)) - 3);
      3: begin
        // first offset value that reaches a code step, or the one just below it
        t = (16384 * int'($urandom_range(1, 15)) - 8192 + 14) / 15;
        return 16'(t - 8192 - int'($urandom_range(0, 1)));
      end
      default: return 16'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  initial begin
    logic signed [15:0] edge_coefs [14];
    logic [8:0] edge_pitches [9];
    logic signed [15:0] coefs [10];
    int unsigned burst;
    int unsigned sent;

    edge_coefs = '{-16'sd32768, -16'sd8193, -16'sd8192, -16'sd8191, -16'sd7646,
                   -16'sd7645, -16'sd1, 16'sd0, 16'sd1, 16'sd8191, 16'sd8192,
                   16'sd8193, 16'sd32767, 16'sd4096};
    edge_pitches = '{9'd0, 9'd1, 9'd19, 9'd20, 9'd21, 9'd141, 9'd142, 9'd143, 9'd511};

    cycles = 0;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    gain_i <= '0;
    pitch_i <= '0;
    foreach (coef_in[k]) coef_in[k] <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of every field
    foreach (coefs[k]) coefs[k] = 16'sd0;
    send_frame(25'd0, 9'd0, coefs);
    foreach (coefs[k]) coefs[k] = 16'sd32767;
    send_frame(25'h1FF_FFFF, 9'd511, coefs);
    foreach (coefs[k]) coefs[k] = -16'sd32768;
    send_frame(25'd1, 9'd1, coefs);

    // each gain threshold, on it or one below, with pitch and clamp edges rotating
    for (int i = 0; i < NumSteps; i++) begin
      foreach (coefs[k]) coefs[k] = edge_coefs[(i + k) % 14];
      send_frame(GainStep[i] - 25'(i % 2), edge_pitches[i % 9], coefs);
      if (i % 4 == 3) hold_off(i / 4 + 1);
    end
    drain_frames();

    sent = 0;
    while (sent < RandItems) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < RandItems) begin
        if (sent == RandItems / 2) drain_frames();
        foreach (coefs[k]) coefs[k] = rand_coef();
        send_frame(rand_gain(), rand_pitch(), coefs);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end

    drain_frames();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
